FILE: sv/tsols_pkg.sv
// Shared constants, register codes and sine table generator for the synth core.
package tsols_pkg;

  localparam int STEP_W   = 32;
  localparam int COEF_W   = 16;
  localparam int GAIN_W   = 20;
  localparam int SAMPLE_W = 16;
  localparam int SINE_W   = 15;
  localparam int ACC_W    = 32;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 32;

  localparam logic [COEF_W-1:0] COEF_RST   = 16'd16384;
  localparam logic [STEP_W-1:0] A_STEP_RST = 32'd11930465;
  localparam logic [STEP_W-1:0] B_STEP_RST = 32'd11954326;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 20'd100000;
  localparam logic [COEF_W-1:0] COEF_ONE   = 16'h8000;
  localparam logic [SINE_W-1:0] FULL_SCALE = 15'd32767;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [IDX_W-1:0] {
    REG_FILTER_COEF = 3'd0,
    REG_OSC_A_STEP  = 3'd1,
    REG_OSC_B_STEP  = 3'd2,
    REG_DRIVE_GAIN  = 3'd3
  } cfg_reg_t;

  // Quarter-wave entry k of a table with 2^(stb-2) steps, Taylor series in Q30.
  function automatic logic [SINE_W-1:0] quarter_value(input int unsigned k,
                                                      input int unsigned stb);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] s;
    x  = 64'(k) << (32 - stb);
    t  = (x * HALF_PI_Q30) >> 30;
    t2 = (t * t) >> 30;
    r  = Q30_ONE;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd110;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd72;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd42;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd20;
    r  = Q30_ONE - ((t2 * r) >> 30) / 64'd6;
    s  = (t * r) >> 30;
    s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SINE_W-1:0];
  endfunction

endpackage

FILE: sv/tsols_shift_mult.sv
// Unsigned shift-add multiplier, one multiplier bit per cycle.
module tsols_shift_mult #(
  parameter int A_W = 16,
  parameter int B_W = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CW = $clog2(B_W);

  logic [A_W-1:0] a_r;
  logic [A_W-1:0] hi_r;
  logic [B_W-1:0] lo_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [A_W:0]   sum_nxt;

  assign sum_nxt = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : {(A_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum_nxt[A_W:1];
      lo_r <= {sum_nxt[0], lo_r[B_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

FILE: sv/two_sine_overdrive_lowpass_synth_core.sv
// Two-sine overdrive synth with one-pole lowpass, bit-serial datapath.
// An accepted tick request runs through the bit-serial phase adders and the two shift-add
// multipliers (20 and 16 steps) before out_tvalid is raised.
// One request at a time: a new one is accepted only after the last sample enters the output register.
// A request with tick low is accepted in S_IDLE and changes nothing.
// Reset (rst_n low, synchronous): registers to defaults, phase A 0, phase B half turn, acc 0.
module two_sine_overdrive_lowpass_synth_core #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] tick
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [15:0] sample
  input  logic                          cfg_wen,
  input  logic [tsols_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tsols_pkg::DATA_W-1:0]  cfg_wdata
);

  localparam int Q     = 1 << (SINE_TABLE_BITS - 2);
  localparam int KW    = SINE_TABLE_BITS - 2;
  localparam int TW    = SINE_TABLE_BITS - 1;
  localparam int CNT_W = (PHASE_BITS > 32) ? $clog2(PHASE_BITS) : 5;
  localparam int SW    = tsols_pkg::SINE_W;
  localparam int GW    = tsols_pkg::GAIN_W;
  localparam int CW    = tsols_pkg::COEF_W;
  localparam int AW    = tsols_pkg::ACC_W;
  localparam int GP_W  = 16 + GW;
  localparam int CP_W  = AW + 1 + CW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PHASE = 8'b0000_0010,
    S_LOOK  = 8'b0000_0100,
    S_SUM   = 8'b0000_1000,
    S_GAIN  = 8'b0001_0000,
    S_DIFF  = 8'b0010_0000,
    S_FILT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [CW-1:0]                   coef_r;
  logic [tsols_pkg::STEP_W-1:0]    a_step_r;
  logic [tsols_pkg::STEP_W-1:0]    b_step_r;
  logic [GW-1:0]                   gain_r;

  logic [PHASE_BITS-1:0] phase_a_r;
  logic [PHASE_BITS-1:0] phase_b_r;
  logic                  ca_r;
  logic                  cb_r;
  logic [CNT_W-1:0]      cnt_r;

  logic signed [15:0]    sa_r;
  logic signed [15:0]    sb_r;
  logic                  sneg_r;
  logic signed [15:0]    drv_r;
  logic                  fneg_r;
  logic signed [AW-1:0]  acc_r;
  logic [15:0]           out_data_r;
  logic                  out_valid_r;

  logic [SW-1:0]         qtab [0:Q];

  for (genvar k = 0; k <= Q; k++) begin : g_qtab
    assign qtab[k] = tsols_pkg::quarter_value(k, SINE_TABLE_BITS);
  end

  // Serial phase adders
  logic step_ok;
  logic a_sbit;
  logic b_sbit;
  logic a_sum;
  logic b_sum;
  logic phase_last;

  assign step_ok    = ({1'b0, cnt_r} < (CNT_W + 1)'(tsols_pkg::STEP_W));
  assign a_sbit     = step_ok & a_step_r[cnt_r[4:0]];
  assign b_sbit     = step_ok & b_step_r[cnt_r[4:0]];
  assign a_sum      = phase_a_r[0] ^ a_sbit ^ ca_r;
  assign b_sum      = phase_b_r[0] ^ b_sbit ^ cb_r;
  assign phase_last = (cnt_r == CNT_W'(PHASE_BITS - 1));

  // Sine lookup
  logic [SINE_TABLE_BITS-1:0] idx_a;
  logic [SINE_TABLE_BITS-1:0] idx_b;
  logic [TW-1:0]              ti_a;
  logic [TW-1:0]              ti_b;
  logic [SW-1:0]              va;
  logic [SW-1:0]              vb;
  logic signed [15:0]         sa_nxt;
  logic signed [15:0]         sb_nxt;

  assign idx_a  = phase_a_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign idx_b  = phase_b_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign ti_a   = idx_a[KW] ? (TW'(Q) - {1'b0, idx_a[KW-1:0]}) : {1'b0, idx_a[KW-1:0]};
  assign ti_b   = idx_b[KW] ? (TW'(Q) - {1'b0, idx_b[KW-1:0]}) : {1'b0, idx_b[KW-1:0]};
  assign va     = qtab[ti_a];
  assign vb     = qtab[ti_b];
  assign sa_nxt = idx_a[KW+1] ? -$signed({1'b0, va}) : $signed({1'b0, va});
  assign sb_nxt = idx_b[KW+1] ? -$signed({1'b0, vb}) : $signed({1'b0, vb});

  // Sine sum magnitude into the gain multiplier
  logic signed [16:0] ssum;
  logic [15:0]        smag;
  logic               g_done;
  logic [GP_W-1:0]    g_prod;

  assign ssum = {sa_r[15], sa_r} + {sb_r[15], sb_r};
  assign smag = ssum[16] ? 16'(-ssum) : ssum[15:0];

  tsols_shift_mult #(.A_W(16), .B_W(GW)) u_gain_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SUM),
    .a     (smag),
    .b     (gain_r),
    .done  (g_done),
    .prod  (g_prod)
  );

  // Clip
  logic [GP_W-16:0]   g_hi;
  logic [SW-1:0]      dmag;
  logic signed [15:0] drv_nxt;

  assign g_hi    = g_prod[GP_W-1:15];
  assign dmag    = (g_hi > (GP_W - 15)'(tsols_pkg::FULL_SCALE)) ? tsols_pkg::FULL_SCALE
                                                                  : g_hi[SW-1:0];
  assign drv_nxt = sneg_r ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

  // Lowpass difference into the coefficient multiplier
  logic signed [AW:0] target;
  logic signed [AW:0] acc_x;
  logic signed [AW:0] d_pos;
  logic signed [AW:0] d_neg;
  logic [AW:0]        d_mag;
  logic [CW-1:0]      coef_eff;
  logic               c_done;
  logic [CP_W-1:0]    c_prod;

  assign target   = {drv_r[15], drv_r, 16'h0000};
  assign acc_x    = {acc_r[AW-1], acc_r};
  assign d_pos    = target - acc_x;
  assign d_neg    = acc_x - target;
  assign d_mag    = d_pos[AW] ? d_neg : d_pos;
  assign coef_eff = coef_r[CW-1] ? tsols_pkg::COEF_ONE : coef_r;

  tsols_shift_mult #(.A_W(AW + 1), .B_W(CW)) u_coef_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIFF),
    .a     (d_mag),
    .b     (coef_eff),
    .done  (c_done),
    .prod  (c_prod)
  );

  logic [CP_W-16:0]   delta;
  logic signed [CP_W-15:0] acc_w;
  logic signed [CP_W-15:0] acc_sum;
  logic [15:0]        samp;
  logic               out_free;
  logic               out_valid_nxt;

  assign delta    = c_prod[CP_W-1:15];
  assign acc_w    = (CP_W - 14)'(acc_r);
  assign acc_sum  = fneg_r ? (acc_w - $signed({1'b0, delta})) : (acc_w + $signed({1'b0, delta}));
  assign samp     = acc_r[AW-1:16] + 16'(acc_r[AW-1] && (acc_r[15:0] != 16'h0000));
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tdata[0]) begin
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        if (phase_last) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_GAIN;
      S_GAIN: begin
        if (g_done) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF:  state_nxt = S_FILT;
      S_FILT: begin
        if (c_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (state_r == S_OUT && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      coef_r      <= tsols_pkg::COEF_RST;
      a_step_r    <= tsols_pkg::A_STEP_RST;
      b_step_r    <= tsols_pkg::B_STEP_RST;
      gain_r      <= tsols_pkg::GAIN_RST;
      phase_a_r   <= '0;
      phase_b_r   <= {1'b1, {(PHASE_BITS-1){1'b0}}};
      acc_r       <= '0;
      cnt_r       <= '0;
      ca_r        <= 1'b0;
      cb_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        case (cfg_index)
          tsols_pkg::REG_FILTER_COEF: coef_r   <= cfg_wdata[CW-1:0];
          tsols_pkg::REG_OSC_A_STEP:  a_step_r <= cfg_wdata[tsols_pkg::STEP_W-1:0];
          tsols_pkg::REG_OSC_B_STEP:  b_step_r <= cfg_wdata[tsols_pkg::STEP_W-1:0];
          tsols_pkg::REG_DRIVE_GAIN:  gain_r   <= cfg_wdata[GW-1:0];
          default: ;
        endcase
      end
      if (state_r == S_IDLE) begin
        cnt_r <= '0;
        ca_r  <= 1'b0;
        cb_r  <= 1'b0;
      end else if (state_r == S_PHASE) begin
        cnt_r     <= cnt_r + CNT_W'(1);
        ca_r      <= (phase_a_r[0] & a_sbit) | (ca_r & (phase_a_r[0] ^ a_sbit));
        cb_r      <= (phase_b_r[0] & b_sbit) | (cb_r & (phase_b_r[0] ^ b_sbit));
        phase_a_r <= {a_sum, phase_a_r[PHASE_BITS-1:1]};
        phase_b_r <= {b_sum, phase_b_r[PHASE_BITS-1:1]};
      end
      if (state_r == S_FILT && c_done) begin
        acc_r <= acc_sum[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
    if (state_r == S_SUM) begin
      sneg_r <= ssum[16];
    end
    if (state_r == S_GAIN && g_done) begin
      drv_r <= drv_nxt;
    end
    if (state_r == S_DIFF) begin
      fneg_r <= d_pos[AW];
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= samp;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
